// File: src/vmdp_pkg.sv
package vmdp_pkg;

  // VRAM depth in words; must be a power of two
  localparam int VMDP_VRAM_WORDS     = 32768;
  localparam int VMDP_OAM_HIGH_BYTES = 32;

  localparam logic OP_REG_WRITE = 1'b0;
  localparam logic OP_VBLANK    = 1'b1;

  // Register offsets within the video register window
  localparam logic [5:0] REG_DISPLAY     = 6'h00;
  localparam logic [5:0] REG_OAM_ADDR_LO = 6'h02;
  localparam logic [5:0] REG_OAM_ADDR_HI = 6'h03;
  localparam logic [5:0] REG_OAM_DATA    = 6'h04;
  localparam logic [5:0] REG_VRAM_MODE   = 6'h15;
  localparam logic [5:0] REG_VRAM_ADDR_LO = 6'h16;
  localparam logic [5:0] REG_VRAM_ADDR_HI = 6'h17;
  localparam logic [5:0] REG_VRAM_DATA_LO = 6'h18;
  localparam logic [5:0] REG_VRAM_DATA_HI = 6'h19;
  localparam logic [5:0] REG_CG_ADDR     = 6'h21;
  localparam logic [5:0] REG_CG_DATA     = 6'h22;
  localparam logic [5:0] REG_OAM_STEP    = 6'h38;
  localparam logic [5:0] REG_VRAM_STEP_A = 6'h39;
  localparam logic [5:0] REG_VRAM_STEP_B = 6'h3A;
  localparam logic [5:0] REG_OAM_HI_POKE = 6'h3F;

  // Fixed OAM high-table byte written through the poke register
  localparam logic [15:0] OAM_HI_POKE_ADDR = 16'h0018;
  localparam int          OAM_HI_IDX_W     = $clog2(VMDP_OAM_HIGH_BYTES);

  typedef enum logic [1:0] {
    TGT_VRAM   = 2'd0,
    TGT_OAM_LO = 2'd1,
    TGT_OAM_HI = 2'd2,
    TGT_CGRAM  = 2'd3
  } target_t;

  typedef struct packed {
    logic       opcode;
    logic [5:0] reg_index;
    logic [7:0] value;
  } vmdp_in_t;

  typedef struct packed {
    target_t     target;
    logic [14:0] mem_addr;
    logic [15:0] word;
  } vmdp_out_t;

  // Memory write request leaving the register stage
  typedef struct packed {
    logic        valid;
    logic        is_vram;
    logic        hi_byte;
    target_t     target;
    logic [15:0] addr;
    logic [15:0] word;
  } vmdp_req_t;

  function automatic logic [7:0] step_lookup(input logic [1:0] code);
    logic [7:0] s;
    unique case (code)
      2'd0:    s = 8'd1;
      2'd1:    s = 8'd32;
      default: s = 8'd128;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] vram_remap(input logic [1:0] mode, input logic [15:0] p);
    logic [15:0] a;
    unique case (mode)
      2'd1:    a = {p[15:8],  p[4:0], p[7:5]};
      2'd2:    a = {p[15:9],  p[5:0], p[8:6]};
      2'd3:    a = {p[15:10], p[6:0], p[9:7]};
      default: a = p;
    endcase
    return a;
  endfunction

endpackage

// File: src/vmdp_ctrl.sv
module vmdp_ctrl
  import vmdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  vmdp_in_t  item,
  output vmdp_req_t req
);

  logic [15:0] vram_ptr_r, vram_ptr_nxt;
  logic        inc_high_r, inc_high_nxt;
  logic [7:0]  inc_step_r, inc_step_nxt;
  logic [1:0]  remap_r, remap_nxt;
  logic [9:0]  oam_ptr_r, oam_ptr_nxt;
  logic [7:0]  oam_base_lo_r, oam_base_lo_nxt;
  logic        oam_base_hi_r, oam_base_hi_nxt;
  logic [7:0]  oam_latch_r, oam_latch_nxt;
  logic        fblank_r, fblank_nxt;
  logic [7:0]  pal_ptr_r, pal_ptr_nxt;
  logic        pal_tog_r, pal_tog_nxt;
  logic [7:0]  pal_latch_r, pal_latch_nxt;

  logic [15:0] vram_adv;
  logic [7:0]  v;

  assign v        = item.value;
  assign vram_adv = vram_ptr_r + 16'(inc_step_r);

  always_comb begin
    vram_ptr_nxt    = vram_ptr_r;
    inc_high_nxt    = inc_high_r;
    inc_step_nxt    = inc_step_r;
    remap_nxt       = remap_r;
    oam_ptr_nxt     = oam_ptr_r;
    oam_base_lo_nxt = oam_base_lo_r;
    oam_base_hi_nxt = oam_base_hi_r;
    oam_latch_nxt   = oam_latch_r;
    fblank_nxt      = fblank_r;
    pal_ptr_nxt     = pal_ptr_r;
    pal_tog_nxt     = pal_tog_r;
    pal_latch_nxt   = pal_latch_r;
    req             = '0;
    req.target      = TGT_VRAM;

    if (item.opcode == OP_VBLANK) begin
      if (!fblank_r) oam_ptr_nxt = {oam_base_hi_r, oam_base_lo_r, 1'b0};
    end else begin
      unique case (item.reg_index)
        REG_DISPLAY: begin
          if (fblank_r && !v[7]) oam_ptr_nxt = {oam_base_hi_r, oam_base_lo_r, 1'b0};
          fblank_nxt = v[7];
        end
        REG_OAM_ADDR_LO: begin
          oam_base_lo_nxt = v;
          oam_ptr_nxt     = {oam_base_hi_r, v, 1'b0};
        end
        REG_OAM_ADDR_HI: begin
          oam_base_hi_nxt = v[0];
          oam_ptr_nxt     = {v[0], oam_base_lo_r, 1'b0};
        end
        REG_OAM_DATA: begin
          if (oam_ptr_r[9]) begin
            req.valid  = 1'b1;
            req.target = TGT_OAM_HI;
            req.addr   = 16'(oam_ptr_r[OAM_HI_IDX_W-1:0]);
            req.word   = {8'h00, v};
          end else if (oam_ptr_r[0]) begin
            req.valid  = 1'b1;
            req.target = TGT_OAM_LO;
            req.addr   = 16'(oam_ptr_r[9:1]);
            req.word   = {v, oam_latch_r};
          end
          if (!oam_ptr_r[0]) oam_latch_nxt = v;
          oam_ptr_nxt = oam_ptr_r + 10'd1;
        end
        REG_VRAM_MODE: begin
          inc_high_nxt = v[7];
          inc_step_nxt = step_lookup(v[1:0]);
          remap_nxt    = v[3:2];
        end
        REG_VRAM_ADDR_LO: vram_ptr_nxt = {vram_ptr_r[15:8], v};
        REG_VRAM_ADDR_HI: vram_ptr_nxt = {v, vram_ptr_r[7:0]};
        REG_VRAM_DATA_LO, REG_VRAM_DATA_HI: begin
          req.valid   = 1'b1;
          req.is_vram = 1'b1;
          req.hi_byte = (item.reg_index == REG_VRAM_DATA_HI);
          req.target  = TGT_VRAM;
          req.addr    = vram_remap(remap_r, vram_ptr_r);
          req.word    = {8'h00, v};
          if (req.hi_byte == inc_high_r) vram_ptr_nxt = vram_adv;
        end
        REG_CG_ADDR: begin
          pal_ptr_nxt = v;
          pal_tog_nxt = 1'b0;
        end
        REG_CG_DATA: begin
          if (pal_tog_r) begin
            req.valid   = 1'b1;
            req.target  = TGT_CGRAM;
            req.addr    = 16'(pal_ptr_r);
            req.word    = {1'b0, v[6:0], pal_latch_r};
            pal_ptr_nxt = pal_ptr_r + 8'd1;
          end else begin
            pal_latch_nxt = v;
          end
          pal_tog_nxt = !pal_tog_r;
        end
        REG_OAM_STEP: oam_ptr_nxt = oam_ptr_r + 10'd1;
        REG_VRAM_STEP_A, REG_VRAM_STEP_B: vram_ptr_nxt = vram_adv;
        REG_OAM_HI_POKE: begin
          req.valid  = 1'b1;
          req.target = TGT_OAM_HI;
          req.addr   = OAM_HI_POKE_ADDR;
          req.word   = {8'h00, v};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vram_ptr_r    <= '0;
      inc_high_r    <= 1'b0;
      inc_step_r    <= 8'd1;
      remap_r       <= '0;
      oam_ptr_r     <= '0;
      oam_base_lo_r <= '0;
      oam_base_hi_r <= 1'b0;
      oam_latch_r   <= '0;
      fblank_r      <= 1'b0;
      pal_ptr_r     <= '0;
      pal_tog_r     <= 1'b0;
      pal_latch_r   <= '0;
    end else if (accept) begin
      vram_ptr_r    <= vram_ptr_nxt;
      inc_high_r    <= inc_high_nxt;
      inc_step_r    <= inc_step_nxt;
      remap_r       <= remap_nxt;
      oam_ptr_r     <= oam_ptr_nxt;
      oam_base_lo_r <= oam_base_lo_nxt;
      oam_base_hi_r <= oam_base_hi_nxt;
      oam_latch_r   <= oam_latch_nxt;
      fblank_r      <= fblank_nxt;
      pal_ptr_r     <= pal_ptr_nxt;
      pal_tog_r     <= pal_tog_nxt;
      pal_latch_r   <= pal_latch_nxt;
    end
  end

endmodule

// File: src/vmdp_vram.sv
module vmdp_vram
  import vmdp_pkg::*;
#(
  parameter int VRAM_WORDS = VMDP_VRAM_WORDS,
  localparam int AW        = $clog2(VRAM_WORDS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_idx,
  output logic [15:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_idx,
  input  logic [15:0]   wr_data,
  output logic          clearing
);

  logic [15:0]   mem [VRAM_WORDS];
  logic [15:0]   rd_data_r;
  logic          clearing_r;
  logic [AW-1:0] clr_idx_r;
  logic          mem_we;
  logic [AW-1:0] mem_widx;
  logic [15:0]   mem_wdata;

  assign clearing  = clearing_r;
  assign rd_data   = rd_data_r;
  assign mem_we    = clearing_r || wr_en;
  assign mem_widx  = clearing_r ? clr_idx_r : wr_idx;
  assign mem_wdata = clearing_r ? 16'h0000 : wr_data;

  // sweep every word to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(VRAM_WORDS - 1)) clearing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_widx] <= mem_wdata;
    if (rd_en) rd_data_r <= mem[rd_idx];
  end

endmodule

// File: src/video_memory_data_port.sv
// Video memory data ports: VRAM, OAM and palette address/data registers.
// Input channel (in_valid / in_stall / in_item): one register write or one
// enter-vblank event per item. Output channel (out_valid / out_stall /
// out_item): one item for each write that stores into a memory, giving the
// target, the address and the full stored word; other inputs give nothing.
// Throughput: one input item per cycle, sustained, while the output drains.
// Path: a storing write enters the merge stage at the accepting edge, where
// VRAM is read, and moves into the output register once that is free.
// The pace is set by the single VRAM read-modify-write: the read is issued
// when the item is accepted, the merged word is written back as the item
// leaves the merge stage, and a write to the same word by the item just
// ahead is forwarded. Reset: all pointers and latches take their reset
// values and VRAM is swept to zero, one word per cycle, while in_stall holds.
// Receiver stall: the output register holds its item, the merge stage holds
// one more, and in_stall rises only when both are full.
module video_memory_data_port
  import vmdp_pkg::*;
#(
  parameter int VRAM_WORDS = VMDP_VRAM_WORDS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  vmdp_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output vmdp_out_t out_item
);

  localparam int AW = $clog2(VRAM_WORDS);

  logic          in_accept;
  logic          clearing;
  vmdp_req_t     req;

  // merge stage
  logic          s1_valid_r;
  vmdp_req_t     s1_req_r;
  logic [AW-1:0] s1_idx;
  logic          s1_adv;
  logic [15:0]   rd_data;
  logic [15:0]   base_word;
  logic [15:0]   merged;
  logic          vram_wr;

  // last word written back, for forwarding
  logic          wb_valid_r;
  logic [AW-1:0] wb_idx_r;
  logic [15:0]   wb_data_r;

  // output register
  logic          out_valid_r;
  vmdp_out_t     out_item_r;
  vmdp_out_t     out_nxt;
  logic          slot_free;
  logic [15:0]   idx_ext;

  assign slot_free = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && slot_free;
  // hold the input while sweeping VRAM or while the merge stage is blocked
  assign in_stall  = clearing || (s1_valid_r && !slot_free);
  assign in_accept = in_valid && !in_stall;

  vmdp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_item),
    .req    (req)
  );

  vmdp_vram #(
    .VRAM_WORDS (VRAM_WORDS)
  ) u_vram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept && req.is_vram),
    .rd_idx   (req.addr[AW-1:0]),
    .rd_data  (rd_data),
    .wr_en    (vram_wr),
    .wr_idx   (s1_idx),
    .wr_data  (merged),
    .clearing (clearing)
  );

  assign s1_idx  = s1_req_r.addr[AW-1:0];
  assign idx_ext = 16'(s1_idx);
  assign vram_wr = s1_adv && s1_req_r.is_vram;

  // the item ahead may write this word at the same edge as this read: forward the last word written back
  assign base_word = (wb_valid_r && wb_idx_r == s1_idx) ? wb_data_r : rd_data;
  assign merged    = s1_req_r.hi_byte ? {s1_req_r.word[7:0], base_word[7:0]}
                                      : {base_word[15:8], s1_req_r.word[7:0]};

  always_comb begin
    out_nxt.target = s1_req_r.target;
    if (s1_req_r.is_vram) begin
      out_nxt.mem_addr = idx_ext[14:0];
      out_nxt.word     = merged;
    end else begin
      out_nxt.mem_addr = s1_req_r.addr[14:0];
      out_nxt.word     = s1_req_r.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= req.valid;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_req_r <= req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (vram_wr) begin
      wb_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vram_wr) begin
      wb_idx_r  <= s1_idx;
      wb_data_r <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_accept)
    else $error("item accepted during VRAM sweep");

  a_no_merge_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !s1_valid_r)
    else $error("merge stage busy during VRAM sweep");

  a_short_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.target == TGT_CGRAM) |-> !out_item_r.word[15])
    else $error("palette word with bit 15 set");

  a_oam_hi_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.target == TGT_OAM_HI) |-> out_item_r.word[15:8] == 8'h00)
    else $error("OAM high-table item wider than a byte");
`endif

endmodule

// File: test/video_memory_data_port_tb.sv
module video_memory_data_port_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vmdp_pkg::*;

  // Receiver hold-off used to fill the block up, and cycles to wait at the end.
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 100;

  // Tile interleave modes of the VRAM address remap
  localparam logic [1:0] REMAP_LINEAR = 2'd0;
  localparam logic [1:0] REMAP_BITS_8 = 2'd1;
  localparam logic [1:0] REMAP_BITS_9 = 2'd2;

  // Increment step codes in the VRAM mode register
  localparam logic [1:0] STEP_CODE_1  = 2'd0;
  localparam logic [1:0] STEP_CODE_32 = 2'd1;

  // Offsets that do something; the rest of the window is ignored
  localparam logic [5:0] LIVE_REGS [15] = '{
    REG_DISPLAY, REG_OAM_ADDR_LO, REG_OAM_ADDR_HI, REG_OAM_DATA, REG_VRAM_MODE,
    REG_VRAM_ADDR_LO, REG_VRAM_ADDR_HI, REG_VRAM_DATA_LO, REG_VRAM_DATA_HI,
    REG_CG_ADDR, REG_CG_DATA, REG_OAM_STEP, REG_VRAM_STEP_A, REG_VRAM_STEP_B,
    REG_OAM_HI_POKE
  };

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  vmdp_in_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  vmdp_out_t out_item;

  int gap_pct   = 0;
  int stall_pct = 0;
  logic hold_req  = 1'b0;
  int   hold_left = 0;

  int items_sent = 0;
  int mismatches = 0;

  // Expected memory writes, oldest first
  vmdp_out_t pending_writes [$];

  // Shadow copy of the register window and of VRAM
  logic [15:0] vram_shadow [VMDP_VRAM_WORDS];
  logic [15:0] vram_ptr;
  logic        inc_on_high;
  logic [7:0]  inc_step;
  logic [1:0]  remap_mode;
  logic [9:0]  oam_ptr;
  logic [7:0]  oam_base_lo;
  logic        oam_base_hi;
  logic [7:0]  oam_latch;
  logic        blanking;
  logic [7:0]  cg_ptr;
  logic        cg_toggle;
  logic [7:0]  cg_latch;

  video_memory_data_port DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Count the long receiver hold-off down at each edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Stall the result channel: hold during the hold-off, else at random.
  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void shadow_reset();
    foreach (vram_shadow[i]) vram_shadow[i] = '0;
    vram_ptr    = '0;
    inc_on_high = 1'b0;
    inc_step    = 8'd1;
    remap_mode  = REMAP_LINEAR;
    oam_ptr     = '0;
    oam_base_lo = '0;
    oam_base_hi = 1'b0;
    oam_latch   = '0;
    blanking    = 1'b0;
    cg_ptr      = '0;
    cg_toggle   = 1'b0;
    cg_latch    = '0;
  endfunction

  // Rotate the low bits of the pointer so that tile rows interleave.
  function automatic logic [15:0] interleave(input logic [1:0] mode, input logic [15:0] p);
    logic [15:0] a;
    case (mode)
      REMAP_LINEAR: a = p;
      REMAP_BITS_8: a = (p & 16'hFF00) | ((p >> 5) & 16'h0007) | ((p << 3) & 16'h00F8);
      REMAP_BITS_9: a = (p & 16'hFE00) | ((p >> 6) & 16'h0007) | ((p << 3) & 16'h01F8);
      default:      a = (p & 16'hFC00) | ((p >> 7) & 16'h0007) | ((p << 3) & 16'h03F8);
    endcase
    return a;
  endfunction

  function automatic void expect_write(input target_t tgt, input logic [14:0] addr,
                                       input logic [15:0] word);
    vmdp_out_t w;
    w.target   = tgt;
    w.mem_addr = addr;
    w.word     = word;
    pending_writes.push_back(w);
  endfunction

  function automatic void reload_oam_ptr();
    oam_ptr = {oam_base_hi, oam_base_lo, 1'b0};
  endfunction

  // Apply one accepted item to the shadow state and queue any memory write.
  function automatic void apply_item(input vmdp_in_t it);
    logic [7:0]  v;
    int unsigned idx;
    v = it.value;
    if (it.opcode == OP_VBLANK) begin
      if (!blanking) reload_oam_ptr();
      return;
    end
    case (it.reg_index)
      REG_DISPLAY: begin
        // leaving forced blank reloads the OAM pointer
        if (blanking && !v[7]) reload_oam_ptr();
        blanking = v[7];
      end
      REG_OAM_ADDR_LO: begin
        oam_base_lo = v;
        reload_oam_ptr();
      end
      REG_OAM_ADDR_HI: begin
        oam_base_hi = v[0];
        reload_oam_ptr();
      end
      REG_OAM_DATA: begin
        if (oam_ptr[9])
          expect_write(TGT_OAM_HI, 15'(oam_ptr & 10'(VMDP_OAM_HIGH_BYTES - 1)), {8'h00, v});
        else if (oam_ptr[0])
          expect_write(TGT_OAM_LO, 15'(oam_ptr[9:1]), {v, oam_latch});
        // even pointers latch the byte, in the high table too
        if (!oam_ptr[0]) oam_latch = v;
        oam_ptr = oam_ptr + 10'd1;
      end
      REG_VRAM_MODE: begin
        inc_on_high = v[7];
        case (v[1:0])
          STEP_CODE_1:  inc_step = 8'd1;
          STEP_CODE_32: inc_step = 8'd32;
          default:      inc_step = 8'd128;
        endcase
        remap_mode = v[3:2];
      end
      REG_VRAM_ADDR_LO: vram_ptr[7:0]  = v;
      REG_VRAM_ADDR_HI: vram_ptr[15:8] = v;
      REG_VRAM_DATA_LO: begin
        idx = interleave(remap_mode, vram_ptr) % VMDP_VRAM_WORDS;
        vram_shadow[idx][7:0] = v;
        expect_write(TGT_VRAM, 15'(idx), vram_shadow[idx]);
        if (!inc_on_high) vram_ptr = vram_ptr + 16'(inc_step);
      end
      REG_VRAM_DATA_HI: begin
        idx = interleave(remap_mode, vram_ptr) % VMDP_VRAM_WORDS;
        vram_shadow[idx][15:8] = v;
        expect_write(TGT_VRAM, 15'(idx), vram_shadow[idx]);
        if (inc_on_high) vram_ptr = vram_ptr + 16'(inc_step);
      end
      REG_CG_ADDR: begin
        cg_ptr    = v;
        cg_toggle = 1'b0;
      end
      REG_CG_DATA: begin
        if (cg_toggle) begin
          expect_write(TGT_CGRAM, 15'(cg_ptr), {1'b0, v[6:0], cg_latch});
          cg_ptr = cg_ptr + 8'd1;
        end else begin
          cg_latch = v;
        end
        cg_toggle = ~cg_toggle;
      end
      REG_OAM_STEP: oam_ptr = oam_ptr + 10'd1;
      REG_VRAM_STEP_A, REG_VRAM_STEP_B: vram_ptr = vram_ptr + 16'(inc_step);
      REG_OAM_HI_POKE: expect_write(TGT_OAM_HI, OAM_HI_POKE_ADDR[14:0], {8'h00, v});
      default: ;
    endcase
  endfunction

  // Watch both channels at each edge: predict first, then check, so that the
  // order between the two never depends on the scheduler.
  always @(posedge clk) begin : watch
    vmdp_out_t want;
    if (!rst_n) begin
      shadow_reset();
      pending_writes.delete();
    end else begin
      if (in_valid && in_stall === 1'b0) apply_item(in_item);
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write target %0d addr %h word %h",
                                    out_item.target, out_item.mem_addr, out_item.word));
        end else begin
          want = pending_writes.pop_front();
          if (out_item.target !== want.target)
            report_mismatch($sformatf("target: expected %0d, got %0d (addr %h)",
                                      want.target, out_item.target, want.mem_addr));
          if (out_item.mem_addr !== want.mem_addr)
            report_mismatch($sformatf("mem_addr: expected %h, got %h (target %0d)",
                                      want.mem_addr, out_item.mem_addr, want.target));
          if (out_item.word !== want.word)
            report_mismatch($sformatf("word: expected %h, got %h (target %0d addr %h)",
                                      want.word, out_item.word, want.target, want.mem_addr));
        end
      end
    end
  end

  function automatic vmdp_in_t reg_write(input logic [5:0] r, input logic [7:0] v);
    vmdp_in_t it;
    it.opcode    = OP_REG_WRITE;
    it.reg_index = r;
    it.value     = v;
    return it;
  endfunction

  // Vblank carries random offset and byte; both must be ignored.
  function automatic vmdp_in_t vblank_item();
    vmdp_in_t it;
    it.opcode    = OP_VBLANK;
    it.reg_index = 6'($urandom);
    it.value     = 8'($urandom);
    return it;
  endfunction

  // Offer one item, idling first at random, and hold it until accepted.
  task automatic send_item(input vmdp_in_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait for every expected write to come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct   <= 0;
        stall_pct <= 0;
      end
      IDLE_SENDER: begin
        gap_pct   <= 73;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        gap_pct   <= 0;
        stall_pct <= 73;
      end
      default: begin
        gap_pct   <= 27;
        stall_pct <= 27;
      end
    endcase
  endtask

  task automatic test_directed_cases();
    // vblank outside forced blank reloads the OAM pointer; poke and a dead offset
    send_item(vblank_item());
    send_item(reg_write(REG_OAM_HI_POKE, 8'hFF));
    send_item(reg_write(6'h3E, 8'hFF));
    // VRAM pointer at the top: index wraps to the depth, pointer wraps to zero
    send_item(reg_write(REG_VRAM_MODE, 8'h00));
    send_item(reg_write(REG_VRAM_ADDR_LO, 8'hFF));
    send_item(reg_write(REG_VRAM_ADDR_HI, 8'hFF));
    send_item(reg_write(REG_VRAM_DATA_LO, 8'hA5));
    send_item(reg_write(REG_VRAM_DATA_HI, 8'hFF));
    // advance on high byte, largest step, widest remap; merge into one word
    send_item(reg_write(REG_VRAM_MODE, 8'h8F));
    send_item(reg_write(REG_VRAM_DATA_LO, 8'h00));
    send_item(reg_write(REG_VRAM_DATA_HI, 8'h5A));
    send_item(reg_write(REG_VRAM_STEP_A, 8'h00));
    send_item(reg_write(REG_VRAM_STEP_B, 8'hFF));
    // OAM high table, then pointer wrap back into the low table
    send_item(reg_write(REG_OAM_ADDR_HI, 8'h01));
    send_item(reg_write(REG_OAM_ADDR_LO, 8'hFF));
    send_item(reg_write(REG_OAM_DATA, 8'h12));
    send_item(reg_write(REG_OAM_DATA, 8'h34));
    send_item(reg_write(REG_OAM_DATA, 8'h56));
    send_item(reg_write(REG_OAM_DATA, 8'h78));
    // forced blank: vblank leaves the pointer, leaving blank reloads it
    send_item(reg_write(REG_DISPLAY, 8'h80));
    send_item(reg_write(REG_OAM_STEP, 8'h00));
    send_item(vblank_item());
    send_item(reg_write(REG_DISPLAY, 8'h00));
    // palette entry at the top, pointer wraps; bit 15 of the word is dropped
    send_item(reg_write(REG_CG_ADDR, 8'hFF));
    send_item(reg_write(REG_CG_DATA, 8'hFF));
    send_item(reg_write(REG_CG_DATA, 8'hFF));
    wait_drain();
  endtask

  task automatic test_vram_ports();
    int first;
    for (int m = 0; m < 4; m++) begin
      set_idling(idle_mode_t'(m));
      first = items_sent;
      while (items_sent - first < 100) begin
        send_item(reg_write(REG_VRAM_MODE, 8'($urandom)));
        send_item(reg_write(REG_VRAM_ADDR_LO, 8'($urandom)));
        // keep mostly to the bottom rows so words get merged more than once
        if ($urandom_range(0, 2) == 0)
          send_item(reg_write(REG_VRAM_ADDR_HI, 8'($urandom)));
        else
          send_item(reg_write(REG_VRAM_ADDR_HI, 8'($urandom_range(0, 1))));
        repeat ($urandom_range(2, 12)) begin
          case ($urandom_range(0, 9))
            0:          send_item(reg_write(REG_VRAM_STEP_A, 8'($urandom)));
            1:          send_item(reg_write(REG_VRAM_STEP_B, 8'($urandom)));
            2, 3, 4, 5: send_item(reg_write(REG_VRAM_DATA_LO, 8'($urandom)));
            default:    send_item(reg_write(REG_VRAM_DATA_HI, 8'($urandom)));
          endcase
        end
      end
      wait_drain();
    end
  endtask

  task automatic test_oam_ports();
    int first;
    for (int m = 0; m < 4; m++) begin
      set_idling(idle_mode_t'(m));
      first = items_sent;
      while (items_sent - first < 60) begin
        // bit 0 of the high base picks the high table; set it now and then
        if ($urandom_range(0, 2) == 0)
          send_item(reg_write(REG_OAM_ADDR_HI, 8'($urandom)));
        else
          send_item(reg_write(REG_OAM_ADDR_HI, {7'($urandom), 1'b0}));
        send_item(reg_write(REG_OAM_ADDR_LO, 8'($urandom)));
        case ($urandom_range(0, 5))
          0:       send_item(reg_write(REG_DISPLAY, 8'($urandom)));
          1:       send_item(vblank_item());
          2:       send_item(reg_write(REG_OAM_STEP, 8'($urandom)));
          3:       send_item(reg_write(REG_OAM_HI_POKE, 8'($urandom)));
          default: ;
        endcase
        repeat ($urandom_range(2, 20)) send_item(reg_write(REG_OAM_DATA, 8'($urandom)));
      end
      wait_drain();
    end
  endtask

  task automatic test_palette_ports();
    int first;
    for (int m = 0; m < 4; m++) begin
      set_idling(idle_mode_t'(m));
      first = items_sent;
      while (items_sent - first < 60) begin
        // odd burst lengths leave the toggle half way for the next address
        if ($urandom_range(0, 3) != 0) send_item(reg_write(REG_CG_ADDR, 8'($urandom)));
        repeat ($urandom_range(1, 16)) send_item(reg_write(REG_CG_DATA, 8'($urandom)));
      end
      wait_drain();
    end
  endtask

  task automatic test_mixed_traffic();
    int first;
    for (int m = 0; m < 4; m++) begin
      set_idling(idle_mode_t'(m));
      first = items_sent;
      while (items_sent - first < 100) begin
        if ($urandom_range(0, 9) == 0)
          send_item(vblank_item());
        else if ($urandom_range(0, 3) == 0)
          send_item(reg_write(6'($urandom), 8'($urandom)));
        else
          send_item(reg_write(LIVE_REGS[$urandom_range(0, 14)], 8'($urandom)));
      end
      wait_drain();
    end
  endtask

  // Hold the result channel off for a long stretch while items keep coming,
  // so that both internal stages fill and the input stalls.
  task automatic test_backpressure();
    set_idling(IDLE_NONE);
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_item(reg_write(REG_VRAM_MODE, 8'h80));
    send_item(reg_write(REG_VRAM_ADDR_LO, 8'($urandom)));
    send_item(reg_write(REG_VRAM_ADDR_HI, 8'h00));
    repeat (60) begin
      if ($urandom_range(0, 1) == 0)
        send_item(reg_write(REG_VRAM_DATA_LO, 8'($urandom)));
      else
        send_item(reg_write(REG_VRAM_DATA_HI, 8'($urandom)));
    end
    wait_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // the first item waits out the VRAM clearing sweep on in_stall
    test_directed_cases();
    test_vram_ports();
    test_oam_ports();
    test_palette_ports();
    test_mixed_traffic();
    test_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Time limit: well beyond the clearing sweep plus the slowest idling
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
